/* hw/rtl/rk4n_pkg.sv */
// Shared constants, types and helper functions of the imaginary-time RK4 step block.
// Every other file of the block but rk4n_ram uses this package; it depends on nothing.
package rk4n_pkg;

  localparam int MaxAmps = 64;
  localparam int AddrW   = $clog2(MaxAmps);
  localparam int CntW    = $clog2(MaxAmps + 1);

  localparam int AmpW    = 16;
  localparam int TsW     = 16;
  localparam int SumW    = 36;
  localparam int SqW     = 33;
  localparam int RootW   = 18;
  localparam int QuoW    = 31;
  localparam int FracW   = 24;
  localparam int FW      = 34;
  localparam int PW      = 48;
  localparam int AccW    = 82;
  localparam int TW      = AccW - FracW;
  localparam int GainExp = 40;

  localparam int RegIdxW = 1;
  localparam logic [RegIdxW-1:0] RegTimeStep = 1'b0;

  localparam logic [TsW-1:0]  TsReset = 16'd655;
  localparam logic [SumW-1:0] SumMax  = '1;

  typedef logic signed [AmpW-1:0] amp_t;

  typedef struct packed {
    amp_t re;
    amp_t im;
  } cplx_t;

  // Quotient magnitude back to a signed part, with saturation on both sides.
  function automatic amp_t quo_to_amp(input logic [QuoW-1:0] q, input logic neg);
    amp_t res;
    if (!neg) begin
      res = (q > QuoW'(32767)) ? 16'sh7fff : amp_t'(q[AmpW-1:0]);
    end else begin
      res = (q > QuoW'(32768)) ? 16'sh8000 : amp_t'(-q[AmpW-1:0]);
    end
    return res;
  endfunction

endpackage

/* hw/rtl/rk4n_in_if.sv */
// Input channel: one amplitude with its diagonal energy per transaction.
// Depends on rk4n_pkg for the payload types.
interface rk4n_in_if;
  logic                valid;
  logic                ready;
  rk4n_pkg::amp_t      amp_real;
  rk4n_pkg::amp_t      amp_imag;
  rk4n_pkg::amp_t      energy;
  logic                is_last;

  modport source (output valid, amp_real, amp_imag, energy, is_last, input ready);
  modport sink   (input valid, amp_real, amp_imag, energy, is_last, output ready);
endinterface

/* hw/rtl/rk4n_out_if.sv */
// Output channel: one normalized amplitude per transaction.
// Depends on rk4n_pkg for the payload types.
interface rk4n_out_if;
  logic                valid;
  logic                ready;
  rk4n_pkg::amp_t      out_real;
  rk4n_pkg::amp_t      out_imag;
  logic                zero_norm;
  logic                out_last;

  modport source (output valid, out_real, out_imag, zero_norm, out_last, input ready);
  modport sink   (input valid, out_real, out_imag, zero_norm, out_last, output ready);
endinterface

/* hw/rtl/rk4n_ram.sv */
// Generic single-clock RAM: one write port, one read port with registered data.
// Standalone; no package needed.
module rk4n_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hw/rtl/rk4n_scale.sv */
// Gain unit: evaluates the RK4 polynomial in Horner form with a digit-serial
// multiplier and a radix-256 divide-by-three, then scales both parts. Uses rk4n_pkg.
module rk4n_scale (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [rk4n_pkg::TsW-1:0] time_step_i,
  input  rk4n_pkg::amp_t           energy_i,
  input  rk4n_pkg::amp_t           amp_re_i,
  input  rk4n_pkg::amp_t           amp_im_i,
  output logic                     done_o,
  output rk4n_pkg::cplx_t          res_o
);
  import rk4n_pkg::*;

  typedef enum logic [4:0] {
    SC_IDLE = 5'b00001,
    SC_F    = 5'b00010,
    SC_MUL  = 5'b00100,
    SC_POST = 5'b01000,
    SC_DIV3 = 5'b10000
  } sc_state_e;

  // Which product the multiplier is working on.
  typedef enum logic [2:0] {
    STG_P3 = 3'd0,
    STG_P2 = 3'd1,
    STG_G  = 3'd2,
    STG_RE = 3'd3,
    STG_IM = 3'd4
  } stg_e;

  localparam int DigW       = 16;
  localparam int Div3Steps  = PW / 8;
  localparam logic signed [PW-1:0]   OneP    = PW'(1 << FracW);
  localparam logic signed [TW-1:0]   OneT    = TW'(1 << FracW);
  localparam logic signed [TW-1:0]   GainMax = TW'(64'sd1 <<< GainExp);
  localparam logic signed [AccW-1:0] Half    = AccW'(1 << (FracW - 1));

  sc_state_e st_q, st_d;
  stg_e      stg_q, stg_d;

  logic [TsW-1:0]          ts_q;
  amp_t                    en_q, ar_q, ai_q;
  logic signed [FW-1:0]    f_q, f_d;
  logic signed [PW-1:0]    p_q, p_d;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic [1:0]              dig_q, dig_d;
  logic [PW-1:0]           m_q, m_d, q_q, q_d;
  logic [1:0]              rem_q, rem_d;
  logic                    neg_q, neg_d;
  logic [2:0]              dcnt_q, dcnt_d;
  amp_t                    sr_q, sr_d, si_q, si_d;

  logic signed [FW-1:0]    a_op;
  logic signed [DigW:0]    dig_op;
  logic signed [FW+DigW:0] part;
  logic signed [AccW-1:0]  part_x;
  logic signed [TW-1:0]    t_v, rnd_v, tmp_v, amp_v;
  logic signed [AccW-1:0]  rnd_full;
  logic signed [2*AmpW:0]  ts_en;
  logic [2:0]              r3;
  logic [1:0]              rem_v;
  logic [7:0]              qb;
  logic [PW-1:0]           q_next;

  // Multiplier operand and one digit of the Horner value or gain.
  always_comb begin
    case (stg_q)
      STG_RE:  a_op = FW'(ar_q);
      STG_IM:  a_op = FW'(ai_q);
      default: a_op = f_q;
    endcase
    if (dig_q == 2'd2) begin
      dig_op = {p_q[PW-1], p_q[PW-1 -: DigW]};
    end else begin
      dig_op = {1'b0, p_q[DigW*dig_q +: DigW]};
    end
    part   = a_op * dig_op;
    part_x = AccW'(part);
    acc_d  = acc_q + (part_x <<< {dig_q, 4'b0000});
  end

  // Eight bits of floor division by three per cycle.
  always_comb begin
    rem_v = rem_q;
    qb    = '0;
    r3    = '0;
    for (int i = 0; i < 8; i++) begin
      r3 = {rem_v, m_q[PW-1-i]};
      if (r3 >= 3'd3) begin
        qb[7-i] = 1'b1;
        r3      = r3 - 3'd3;
      end
      rem_v = r3[1:0];
    end
    q_next = {q_q[PW-9:0], qb};
  end

  always_comb begin
    ts_en    = $signed({1'b0, ts_q}) * en_q;
    f_d      = -FW'(ts_en);
    t_v      = acc_q[AccW-1:FracW];
    rnd_full = acc_q + Half;
    rnd_v    = rnd_full[AccW-1:FracW];
    if (rnd_v > TW'(32767)) begin
      amp_v = TW'(32767);
    end else if (rnd_v < -TW'(32768)) begin
      amp_v = -TW'(32768);
    end else begin
      amp_v = rnd_v;
    end
    tmp_v = '0;

    st_d   = st_q;
    stg_d  = stg_q;
    p_d    = p_q;
    dig_d  = dig_q;
    m_d    = m_q;
    q_d    = q_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    dcnt_d = dcnt_q;
    sr_d   = sr_q;
    si_d   = si_q;
    done_o = 1'b0;

    case (st_q)
      SC_IDLE: begin
        if (start_i) begin
          st_d = SC_F;
        end
      end
      SC_F: begin
        p_d   = OneP + PW'(f_d >>> 2);
        stg_d = STG_P3;
        dig_d = '0;
        st_d  = SC_MUL;
      end
      SC_MUL: begin
        if (dig_q == 2'd2) begin
          dig_d = '0;
          st_d  = SC_POST;
        end else begin
          dig_d = dig_q + 2'd1;
        end
      end
      SC_POST: begin
        dig_d = '0;
        st_d  = SC_MUL;
        case (stg_q)
          STG_P3: begin
            neg_d  = t_v[TW-1];
            tmp_v  = t_v[TW-1] ? (TW'(2) - t_v) : t_v;
            m_d    = tmp_v[PW-1:0];
            q_d    = '0;
            rem_d  = '0;
            dcnt_d = '0;
            st_d   = SC_DIV3;
          end
          STG_P2: begin
            tmp_v = OneT + (t_v >>> 1);
            p_d   = tmp_v[PW-1:0];
            stg_d = STG_G;
          end
          STG_G: begin
            tmp_v = OneT + t_v;
            if (tmp_v[TW-1]) begin
              p_d = '0;
            end else if (tmp_v > GainMax) begin
              p_d = GainMax[PW-1:0];
            end else begin
              p_d = tmp_v[PW-1:0];
            end
            stg_d = STG_RE;
          end
          STG_RE: begin
            sr_d  = amp_v[AmpW-1:0];
            stg_d = STG_IM;
          end
          STG_IM: begin
            si_d   = amp_v[AmpW-1:0];
            done_o = 1'b1;
            st_d   = SC_IDLE;
          end
          default: st_d = SC_IDLE;
        endcase
      end
      SC_DIV3: begin
        m_d    = {m_q[PW-9:0], 8'h00};
        q_d    = q_next;
        rem_d  = rem_v;
        dcnt_d = dcnt_q + 3'd1;
        if (dcnt_q == 3'(Div3Steps - 1)) begin
          p_d   = OneP + (neg_q ? -$signed(q_next) : $signed(q_next));
          stg_d = STG_P2;
          dig_d = '0;
          st_d  = SC_MUL;
        end
      end
      default: st_d = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SC_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == SC_IDLE && start_i) begin
      ts_q <= time_step_i;
      en_q <= energy_i;
      ar_q <= amp_re_i;
      ai_q <= amp_im_i;
    end
    if (st_q == SC_F) begin
      f_q <= f_d;
    end
    if (st_q == SC_MUL) begin
      acc_q <= acc_d;
    end else begin
      acc_q <= '0;
    end
    stg_q  <= stg_d;
    p_q    <= p_d;
    dig_q  <= dig_d;
    m_q    <= m_d;
    q_q    <= q_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    dcnt_q <= dcnt_d;
    sr_q   <= sr_d;
    si_q   <= si_d;
  end

  assign res_o = '{re: sr_d, im: si_d};

endmodule

/* hw/rtl/rk4n_isqrt.sv */
// Integer square root of the accumulated squared magnitude, one result bit per cycle.
// Uses rk4n_pkg for widths.
module rk4n_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rk4n_pkg::SumW-1:0]  value_i,
  output logic                       done_o,
  output logic [rk4n_pkg::RootW-1:0] root_o
);
  import rk4n_pkg::*;

  localparam int SqrtW = SumW + 2;

  logic             busy_q;
  logic [SqrtW-1:0] v_q, res_q, bit_q, trial;

  assign trial  = res_q + bit_q;
  assign done_o = busy_q && bit_q[0];
  assign root_o = (v_q >= trial) ? RootW'((res_q >> 1) + bit_q) : RootW'(res_q >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= SqrtW'(value_i);
      res_q <= '0;
      bit_q <= SqrtW'(1) << SumW;
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule

/* hw/rtl/rk4n_rdiv.sv */
// Restoring divider shared by both parts of each output amplitude, one quotient
// bit per cycle. Uses rk4n_pkg for widths.
module rk4n_rdiv (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rk4n_pkg::QuoW-1:0]  num_i,
  input  logic [rk4n_pkg::RootW-1:0] den_i,
  output logic                       done_o,
  output logic [rk4n_pkg::QuoW-1:0]  quo_o
);
  import rk4n_pkg::*;

  localparam int CntBits = $clog2(QuoW);

  logic               busy_q;
  logic [CntBits-1:0] cnt_q;
  logic [QuoW-1:0]    nq_q;
  logic [RootW-1:0]   den_q, rem_q;
  logic [RootW:0]     rem_sh, rem_sub;
  logic               qbit;

  assign rem_sh  = {rem_q, nq_q[QuoW-1]};
  assign qbit    = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign done_o  = busy_q && (cnt_q == CntBits'(QuoW - 1));
  assign quo_o   = {nq_q[QuoW-2:0], qbit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      nq_q  <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      cnt_q <= '0;
    end else if (busy_q) begin
      rem_q <= qbit ? rem_sub[RootW-1:0] : rem_sh[RootW-1:0];
      nq_q  <= {nq_q[QuoW-2:0], qbit};
      cnt_q <= cnt_q + CntBits'(1);
    end
  end

endmodule

/* hw/rtl/rk4_imag_time_step_normalise_core.sv */
// Top level: imaginary-time RK4 step of a state vector, then normalization.
// Depends on rk4n_pkg, rk4n_in_if, rk4n_out_if, rk4n_ram, rk4n_scale,
// rk4n_isqrt and rk4n_rdiv.
//
//   port      | dir   | transaction
//   ----------+-------+------------------------------------------------
//   in_i      | sink  | amp_real, amp_imag, energy, is_last
//   out_o     | src   | out_real, out_imag, zero_norm, out_last
//   APB       | slave | time_step at byte address 0
//
// Loading takes each amplitude through the gain unit (f, five products and a divide
// by three), then stores, accumulates and takes the next input; no new amplitude is
// accepted until the last one is accumulated.
// After the last amplitude the square root runs; each output then passes through the
// shared divider twice per amplitude, for the real and the imaginary part, or skips
// it when the norm is zero.
// Reset leaves the sum and count empty and the step at 655; the store needs no clearing.
// A stalled output holds its register while the next amplitude is prepared.
module rk4_imag_time_step_normalise_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  rk4n_in_if.sink     in_i,
  rk4n_out_if.source  out_o
);
  import rk4n_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SCALE = 10'b0000000010,
    S_SQ    = 10'b0000000100,
    S_ACC   = 10'b0000001000,
    S_ROOT  = 10'b0000010000,
    S_READ  = 10'b0000100000,
    S_FETCH = 10'b0001000000,
    S_DRE   = 10'b0010000000,
    S_DIM   = 10'b0100000000,
    S_PUT   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [TsW-1:0]   ts_q;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [SumW:0]    sum_w;
  logic [CntW-1:0]  load_cnt_q;
  logic [AddrW-1:0] emit_q;
  logic             last_q;
  cplx_t            cur_q, hold_q;
  logic [SqW-1:0]   sq_q;
  logic [RootW-1:0] r_q;
  amp_t             o_re_q, o_im_q;

  logic             out_valid_q;
  amp_t             out_re_q, out_im_q;
  logic             out_zero_q, out_last_q;

  logic             in_acc, cfg_wr, out_free, is_final;
  logic             scale_done, root_done, root_start, div_start, div_done;
  cplx_t            scale_res;
  logic [RootW-1:0] root;
  logic [QuoW-1:0]  div_num, quo;
  logic [2*AmpW-1:0] rdata;
  cplx_t            rd_amp;
  amp_t             div_src;
  logic [AmpW:0]    div_mag;
  logic [2*AmpW-1:0] sq_re, sq_im;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegTimeStep);
  assign prdata = (paddr[2] == RegTimeStep) ? {{(32 - TsW){1'b0}}, ts_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q <= TsReset;
    end else if (cfg_wr) begin
      ts_q <= pwdata[TsW-1:0];
    end
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign is_final   = ({1'b0, emit_q} + CntW'(1)) == load_cnt_q;
  assign rd_amp     = rdata;

  rk4n_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_acc),
    .time_step_i (ts_q),
    .energy_i    (in_i.energy),
    .amp_re_i    (in_i.amp_real),
    .amp_im_i    (in_i.amp_imag),
    .done_o      (scale_done),
    .res_o       (scale_res)
  );

  rk4n_ram #(.WIDTH(2 * AmpW), .DEPTH(MaxAmps)) u_store (
    .clk_i   (clk_i),
    .we_i    (state_q == S_SQ),
    .waddr_i (load_cnt_q[AddrW-1:0]),
    .wdata_i (cur_q),
    .raddr_i (emit_q),
    .rdata_o (rdata)
  );

  // Saturating accumulation of the squared magnitude.
  always_comb begin
    sq_re = cur_q.re * cur_q.re;
    sq_im = cur_q.im * cur_q.im;
    sum_w = {1'b0, sum_q} + (SumW + 1)'(sq_q);
    sum_d = sum_w[SumW] ? SumMax : sum_w[SumW-1:0];
  end

  assign root_start = (state_q == S_ACC) && (last_q || load_cnt_q == CntW'(MaxAmps));

  rk4n_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .value_i (sum_d),
    .done_o  (root_done),
    .root_o  (root)
  );

  // The real part comes straight from the store, the imaginary part from the hold register.
  always_comb begin
    div_src = (state_q == S_FETCH) ? rd_amp.re : hold_q.im;
    div_mag = div_src[AmpW-1] ? -{div_src[AmpW-1], div_src} : {div_src[AmpW-1], div_src};
    div_num = {div_mag[AmpW-1:0], 15'd0} + QuoW'(r_q >> 1);
    div_start = ((state_q == S_FETCH) && (r_q != '0)) || ((state_q == S_DRE) && div_done);
  end

  rk4n_rdiv u_rdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (r_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_SCALE;
      S_SCALE: if (scale_done) state_d = S_SQ;
      S_SQ:    state_d = S_ACC;
      S_ACC:   state_d = root_start ? S_ROOT : S_IDLE;
      S_ROOT:  if (root_done) state_d = S_READ;
      S_READ:  state_d = S_FETCH;
      S_FETCH: state_d = (r_q == '0) ? S_PUT : S_DRE;
      S_DRE:   if (div_done) state_d = S_DIM;
      S_DIM:   if (div_done) state_d = S_PUT;
      S_PUT: begin
        if (out_free) begin
          state_d = is_final ? S_IDLE : S_READ;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      load_cnt_q  <= '0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_SQ) begin
        load_cnt_q <= load_cnt_q + CntW'(1);
      end
      if (state_q == S_ACC) begin
        sum_q <= sum_d;
      end
      if (state_q == S_ROOT) begin
        emit_q <= '0;
      end
      if (state_q == S_PUT && out_free) begin
        out_valid_q <= 1'b1;
        emit_q      <= emit_q + AddrW'(1);
        if (is_final) begin
          sum_q      <= '0;
          load_cnt_q <= '0;
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      last_q <= in_i.is_last;
    end
    if (scale_done) begin
      cur_q <= scale_res;
    end
    if (state_q == S_SQ) begin
      sq_q <= SqW'(sq_re) + SqW'(sq_im);
    end
    if (root_done) begin
      r_q <= root;
    end
    if (state_q == S_FETCH) begin
      hold_q <= rd_amp;
      o_re_q <= '0;
      o_im_q <= '0;
    end
    if (state_q == S_DRE && div_done) begin
      o_re_q <= quo_to_amp(quo, hold_q.re[AmpW-1]);
    end
    if (state_q == S_DIM && div_done) begin
      o_im_q <= quo_to_amp(quo, hold_q.im[AmpW-1]);
    end
    if (state_q == S_PUT && out_free) begin
      out_re_q   <= o_re_q;
      out_im_q   <= o_im_q;
      out_zero_q <= (r_q == '0);
      out_last_q <= is_final;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_real  = out_re_q;
  assign out_o.out_imag  = out_im_q;
  assign out_o.zero_norm = out_zero_q;
  assign out_o.out_last  = out_last_q;

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input taken while an item is in flight");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_cnt_q <= CntW'(MaxAmps))
    else $error("load count beyond store depth");

  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> {1'b0, emit_q} < load_cnt_q)
    else $error("emission reads past the loaded entries");

  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.zero_norm |-> out_o.out_real == '0 && out_o.out_imag == '0)
    else $error("zero norm with nonzero output");

endmodule

/* dv/rk4n_amp_checker.sv */
// Checker for the imaginary-time RK4 step block: predicts normalized amplitudes
// from the input and APB transactions and compares them. Depends on rk4n_pkg and the channel interfaces.
module rk4n_amp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  rk4n_in_if          in_ch,
  rk4n_out_if         out_ch,
  output int          err_cnt_o,
  output int          pending_o
);
  import rk4n_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    amp_t re;
    amp_t im;
    logic zero;
    logic last;
  } norm_amp_t;

  localparam wide_t OneQ    = wide_t'(1) <<< FracW;
  localparam wide_t GainTop = wide_t'(1) <<< GainExp;

  norm_amp_t   norm_amp_q[$];
  amp_t        re_store[MaxAmps];
  amp_t        im_store[MaxAmps];
  logic [35:0] sq_sum;
  int          n_loaded;
  logic [15:0] step_reg;

  assign pending_o = norm_amp_q.size();

  function automatic wide_t floor_quo(wide_t n, wide_t d);
    wide_t q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic wide_t sat_amp(wide_t v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic logic [63:0] int_root(logic [63:0] v);
    logic [63:0] res, bitv;
    res  = 0;
    bitv = 64'd1 << 36;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic wide_t round_quo(wide_t n, wide_t d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  // Loads one amplitude; on the closing one, queues the normalized vector.
  task automatic rk4_load(amp_t ar, amp_t ai, amp_t en, logic last);
    wide_t       f, p, g, sr, si, r;
    logic [63:0] sum_w;
    int          idx;
    norm_amp_t   e;
    f = -(wide_t'(step_reg) * wide_t'(en));
    p = OneQ + floor_quo(f, 4);
    p = OneQ + floor_quo((f * p) >>> FracW, 3);
    p = OneQ + floor_quo((f * p) >>> FracW, 2);
    g = OneQ + ((f * p) >>> FracW);
    if (g < 0) g = 0;
    if (g > GainTop) g = GainTop;
    sr = sat_amp((wide_t'(ar) * g + (wide_t'(1) <<< (FracW - 1))) >>> FracW);
    si = sat_amp((wide_t'(ai) * g + (wide_t'(1) <<< (FracW - 1))) >>> FracW);
    idx = (n_loaded >= MaxAmps) ? MaxAmps - 1 : n_loaded;
    re_store[idx] = amp_t'(sr);
    im_store[idx] = amp_t'(si);
    sum_w = 64'(sq_sum) + 64'(sr * sr + si * si);
    sq_sum = (sum_w > 64'(SumMax)) ? SumMax : sum_w[35:0];
    n_loaded = idx + 1;
    if (last || n_loaded >= MaxAmps) begin
      r = wide_t'(int_root(64'(sq_sum)));
      for (int k = 0; k < n_loaded; k++) begin
        e.zero = (r == 0);
        e.re   = 0;
        e.im   = 0;
        if (r != 0) begin
          e.re = amp_t'(sat_amp(round_quo(wide_t'(re_store[k]) * 32768, r)));
          e.im = amp_t'(sat_amp(round_quo(wide_t'(im_store[k]) * 32768, r)));
        end
        e.last = (k + 1 == n_loaded);
        norm_amp_q.push_back(e);
      end
      sq_sum   = 0;
      n_loaded = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    norm_amp_t e;
    if (!rst_ni) begin
      sq_sum    = 0;
      n_loaded  = 0;
      step_reg  = TsReset;
      err_cnt_o = 0;
      norm_amp_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == RegTimeStep)
        step_reg = pwdata[15:0];
      if (out_ch.valid && out_ch.ready) begin
        if (norm_amp_q.size() == 0) begin
          $error("unexpected output transaction re=%0d im=%0d", out_ch.out_real,
                 out_ch.out_imag);
          err_cnt_o++;
        end else begin
          e = norm_amp_q.pop_front();
          if (out_ch.out_real !== e.re) begin
            $error("out_real: expected %0d, got %0d", e.re, out_ch.out_real);
            err_cnt_o++;
          end
          if (out_ch.out_imag !== e.im) begin
            $error("out_imag: expected %0d, got %0d", e.im, out_ch.out_imag);
            err_cnt_o++;
          end
          if (out_ch.zero_norm !== e.zero) begin
            $error("zero_norm: expected %0b, got %0b", e.zero, out_ch.zero_norm);
            err_cnt_o++;
          end
          if (out_ch.out_last !== e.last) begin
            $error("out_last: expected %0b, got %0b", e.last, out_ch.out_last);
            err_cnt_o++;
          end
        end
      end
      // Load after the output check, so a vector closed now queues behind older ones.
      if (in_ch.valid && in_ch.ready)
        rk4_load(in_ch.amp_real, in_ch.amp_imag, in_ch.energy, in_ch.is_last);
    end
  end
endmodule

/* dv/tb_rk4_imag_time_step_normalise_core.sv */
// Testbench top for the imaginary-time RK4 step block: clock, reset, APB writes,
// amplitude stimulus and verdict. Depends on rk4n_pkg, the channel interfaces and rk4n_amp_checker.
module tb_rk4_imag_time_step_normalise_core;
  import rk4n_pkg::*;

  localparam int StallLimit = 5000;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          err_cnt, pending, idle_cycles;
  int          tx_idle, rx_idle;
  logic        hold_req;

  rk4n_in_if  in_ch();
  rk4n_out_if out_ch();

  rk4_imag_time_step_normalise_core dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_i(in_ch), .out_o(out_ch)
  );

  rk4n_amp_checker u_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .in_ch, .out_ch, .err_cnt_o(err_cnt), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver: random backpressure, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  // Stall watchdog: cycles with no transaction on either channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("[rk4_imag_time_step_normalise_core] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_amp(int ar, int ai, int en, bit last);
    while ($urandom_range(99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.amp_real <= amp_t'(ar);
    in_ch.amp_imag <= amp_t'(ai);
    in_ch.energy   <= amp_t'(en);
    in_ch.is_last  <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic write_step(logic [15:0] val);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegTimeStep, 2'b00};
    pwdata  <= {16'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic int rand_amp(bit zero_vec);
    if (zero_vec) return 0;
    case ($urandom_range(7))
      0:       return 0;
      1:       return $urandom_range(1) ? 32767 : -32768;
      default: return int'(amp_t'($urandom_range(65535)));
    endcase
  endfunction

  task automatic send_vectors(int n_items);
    int sent, len;
    bit zero_vec;
    sent = 0;
    while (sent < n_items) begin
      len      = ($urandom_range(9) == 0) ? $urandom_range(20, MaxAmps) : $urandom_range(1, 8);
      zero_vec = ($urandom_range(11) == 0);
      for (int k = 0; k < len; k++)
        send_amp(rand_amp(zero_vec), rand_amp(zero_vec),
                 ($urandom_range(9) < 7) ? $urandom_range(512) - 256
                                         : int'(amp_t'($urandom_range(65535))),
                 k == len - 1);
      sent += len;
    end
  endtask

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.amp_real = '0;
    in_ch.amp_imag = '0;
    in_ch.energy   = '0;
    in_ch.is_last  = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    hold_req = 1'b0;
    tx_idle  = 33;
    rx_idle  = 79;
    rst_ni   = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset step, field extremes, single-amplitude vector.
    send_amp(32767, -32768, 0, 1'b0);
    send_amp(-32768, 32767, 32767, 1'b0);
    send_amp(1, -1, -32768, 1'b1);
    send_amp(12345, -222, 100, 1'b1);
    // Zero norm: all amplitudes zero.
    send_amp(0, 0, 5, 1'b0);
    send_amp(0, 0, -5, 1'b1);
    drain();
    // Gain clamped to its maximum by a large step and a large energy.
    write_step(16'hffff);
    send_amp(20000, -20000, 32767, 1'b0);
    send_amp(-32768, 32767, 32767, 1'b1);
    // Strong negative energy saturates every nonzero part.
    send_amp(3, -3, -32768, 1'b0);
    send_amp(0, 1, -32768, 1'b1);
    drain();
    // Full store with a saturating sum: 64 amplitudes and no last flag.
    write_step(16'h0000);
    for (int k = 0; k < MaxAmps; k++) send_amp(-32768, -32768, k * 1000 - 32768, 1'b0);
    drain();
    write_step(16'd655);
    send_vectors(40);
    drain();

    tx_idle = 79;
    rx_idle = 33;
    write_step(16'($urandom_range(65535)));
    send_vectors(40);
    drain();

    tx_idle = 0;
    rx_idle = 0;
    write_step(16'd40);
    hold_req = 1'b1;
    send_vectors(10);
    send_vectors(30);
    drain();
    repeat (200) @(posedge clk_i);

    if (err_cnt == 0 && pending == 0) begin
      $display("[rk4_imag_time_step_normalise_core] OK");
    end else begin
      $display("[rk4_imag_time_step_normalise_core] ERROR");
    end
    $finish;
  end
endmodule
